/* hdl/bshl_pkg.sv */
// ----------------------------------------------------------------------------
// bshl_pkg
// Types, codes and helpers for the bucketed sorted hash lookup block.
// ----------------------------------------------------------------------------
package bshl_pkg;

  localparam int unsigned RECORD_DEPTH_DEF = 4096;
  localparam int unsigned BUCKETS          = 256;
  localparam logic [15:0] FLAG_SHIFT_MARK  = 16'h8000;
  localparam logic [4:0]  FLAG_SHIFT_MASK  = 5'h1F;

  typedef enum logic [1:0] {
    CMD_WR_BUCKET = 2'd0,
    CMD_WR_RECORD = 2'd1,
    CMD_LOOKUP    = 2'd2,
    CMD_MATCH     = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    PART_HASH_HI  = 3'd0,
    PART_HASH_LO  = 3'd1,
    PART_MATCH_HI = 3'd2,
    PART_MATCH_LO = 3'd3,
    PART_FLAG_ID  = 3'd4
  } part_t;

  localparam logic [1:0] ST_NOT_FOUND = 2'd0;
  localparam logic [1:0] ST_FOUND     = 2'd1;
  localparam logic [1:0] ST_MISMATCH  = 2'd2;
  localparam logic [1:0] ST_WRONG     = 2'd3;

  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_PLAIN = 2'd1;
  localparam logic [1:0] KIND_MATCH = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic capture;    // latch query / write fields
    logic do_write;   // perform write from latched fields
    logic rd_bucket;  // read bucket memory
    logic load_idx;   // index from bucket data
    logic rd_record;  // read record at index
    logic step;       // evaluate record, advance index
    logic set_wrong;
    logic clr_result;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_write;
    logic kind_ok;
    logic kind_none;
    logic bucket_empty;
    logic idx_oob;
    logic walk_done;
  } dp_status_t;

  function automatic logic [31:0] decode_flags(input logic [15:0] f);
    if ((f & FLAG_SHIFT_MARK) != 16'd0) begin
      return 32'd1 << (f[4:0] & FLAG_SHIFT_MASK);
    end
    return {16'd0, f};
  endfunction

endpackage

/* hdl/bshl_if.sv */
// ----------------------------------------------------------------------------
// bshl_in_if / bshl_out_if / bshl_cfg_if
// Valid/ready channels of the lookup block.
// ----------------------------------------------------------------------------
interface bshl_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [11:0] slot;
  logic [2:0]  part;
  logic [63:0] load_word;
  logic [63:0] hash_hi;
  logic [63:0] hash_lo;
  logic [63:0] match_hi;
  logic [63:0] match_lo;
  modport source (output valid, cmd, slot, part, load_word, hash_hi, hash_lo,
                  match_hi, match_lo, input ready);
  modport sink (input valid, cmd, slot, part, load_word, hash_hi, hash_lo,
                match_hi, match_lo, output ready);
endinterface

interface bshl_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] flags;
  logic [15:0] entry_id;
  modport source (output valid, status, flags, entry_id, input ready);
  modport sink (input valid, status, flags, entry_id, output ready);
endinterface

interface bshl_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

/* hdl/bshl_ctrl.sv */
// ----------------------------------------------------------------------------
// bshl_ctrl
// Sequencer for writes, bucket read and record walk.
// ----------------------------------------------------------------------------
module bshl_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output bshl_pkg::dp_cmd_t     cmd,
  input  bshl_pkg::dp_status_t  sts
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_BUCKET = 7'b0000100,
    S_INDEX  = 7'b0001000,
    S_READ   = 7'b0010000,
    S_EVAL   = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.clr_result = 1'b1;
        priority if (sts.is_write) begin
          cmd.do_write = 1'b1;
          state_nxt    = S_IDLE;
        end else if (sts.kind_none) begin
          state_nxt = S_OUT;
        end else if (!sts.kind_ok) begin
          cmd.set_wrong = 1'b1;
          state_nxt     = S_OUT;
        end else begin
          cmd.rd_bucket = 1'b1;
          state_nxt     = S_BUCKET;
        end
      end
      S_BUCKET: begin
        cmd.load_idx = 1'b1;
        state_nxt    = S_INDEX;
      end
      S_INDEX: begin
        if (sts.bucket_empty || sts.idx_oob) begin
          state_nxt = S_OUT;
        end else begin
          cmd.rd_record = 1'b1;
          state_nxt     = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        cmd.step = 1'b1;
        if (sts.walk_done) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_INDEX;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

/* hdl/bshl_dp.sv */
// ----------------------------------------------------------------------------
// bshl_dp
// Bucket and record memories, compare and result registers.
// ----------------------------------------------------------------------------
module bshl_dp #(
  parameter int unsigned RECORD_DEPTH = bshl_pkg::RECORD_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [1:0]            table_kind,
  input  logic [1:0]            in_cmd,
  input  logic [11:0]           in_slot,
  input  logic [2:0]            in_part,
  input  logic [63:0]           in_load_word,
  input  logic [63:0]           in_hash_hi,
  input  logic [63:0]           in_hash_lo,
  input  logic [63:0]           in_match_hi,
  input  logic [63:0]           in_match_lo,
  input  bshl_pkg::dp_cmd_t     cmd,
  output bshl_pkg::dp_status_t  sts,
  output logic [1:0]            out_status,
  output logic [31:0]           out_flags,
  output logic [15:0]           out_entry_id
);

  localparam int unsigned AW = $clog2(RECORD_DEPTH);
  localparam int unsigned IW = 16;

  logic [1:0]  cmd_r;
  logic [11:0] slot_r;
  logic [2:0]  part_r;
  logic [63:0] word_r, qh_r, ql_r, mh_r, ml_r;

  logic [15:0] bucket_mem [bshl_pkg::BUCKETS];
  logic [bshl_pkg::BUCKETS-1:0] bucket_vld_r;
  logic [15:0] bucket_q_r;
  logic        bucket_qv_r;

  logic [63:0] hh_mem [RECORD_DEPTH];
  logic [63:0] hl_mem [RECORD_DEPTH];
  logic [63:0] mhm_mem [RECORD_DEPTH];
  logic [63:0] mlm_mem [RECORD_DEPTH];
  logic [31:0] fi_mem [RECORD_DEPTH];
  logic [63:0] hh_q_r, hl_q_r, mh_q_r, ml_q_r;
  logic [31:0] fi_q_r;

  logic [IW-1:0] idx_r;
  logic [1:0]    status_r;
  logic [31:0]   flags_r;
  logic [15:0]   id_r;

  logic rec_slot_ok;
  assign rec_slot_ok = ({4'd0, slot_r} < 16'(RECORD_DEPTH));

  logic [AW-1:0] wr_addr;
  assign wr_addr = AW'(slot_r);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r  <= in_cmd;
      slot_r <= in_slot;
      part_r <= in_part;
      word_r <= in_load_word;
      qh_r   <= in_hash_hi;
      ql_r   <= in_hash_lo;
      mh_r   <= in_match_hi;
      ml_r   <= in_match_lo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bucket_vld_r <= '0;
    end else if (cmd.do_write && cmd_r == bshl_pkg::CMD_WR_BUCKET && slot_r[11:8] == 4'd0) begin
      bucket_vld_r[slot_r[7:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_write && cmd_r == bshl_pkg::CMD_WR_BUCKET && slot_r[11:8] == 4'd0) begin
      bucket_mem[slot_r[7:0]] <= word_r[15:0];
    end
    if (cmd.rd_bucket) begin
      bucket_q_r  <= bucket_mem[qh_r[63:56]];
      bucket_qv_r <= bucket_vld_r[qh_r[63:56]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_write && cmd_r == bshl_pkg::CMD_WR_RECORD && rec_slot_ok) begin
      unique case (part_r)
        bshl_pkg::PART_HASH_HI:  hh_mem[wr_addr]  <= word_r;
        bshl_pkg::PART_HASH_LO:  hl_mem[wr_addr]  <= word_r;
        bshl_pkg::PART_MATCH_HI: mhm_mem[wr_addr] <= word_r;
        bshl_pkg::PART_MATCH_LO: mlm_mem[wr_addr] <= word_r;
        bshl_pkg::PART_FLAG_ID:  fi_mem[wr_addr]  <= word_r[31:0];
        default: ;
      endcase
    end
    if (cmd.rd_record) begin
      hh_q_r <= hh_mem[idx_r[AW-1:0]];
      hl_q_r <= hl_mem[idx_r[AW-1:0]];
      mh_q_r <= mhm_mem[idx_r[AW-1:0]];
      ml_q_r <= mlm_mem[idx_r[AW-1:0]];
      fi_q_r <= fi_mem[idx_r[AW-1:0]];
    end
  end

  logic [15:0] bucket_eff;
  assign bucket_eff = bucket_qv_r ? bucket_q_r : 16'd0;

  logic q_eq, q_lt, first_eq, m_eq, is_plain;
  assign first_eq = (hh_q_r[63:56] == qh_r[63:56]);
  assign q_eq     = (qh_r == hh_q_r) && (ql_r == hl_q_r);
  assign q_lt     = (qh_r < hh_q_r) || ((qh_r == hh_q_r) && (ql_r < hl_q_r));
  assign m_eq     = (mh_q_r == mh_r) && (ml_q_r == ml_r);
  assign is_plain = (cmd_r == bshl_pkg::CMD_LOOKUP);

  always_ff @(posedge clk) begin
    if (cmd.load_idx) begin
      idx_r <= IW'(bucket_eff - 16'd1);
    end else if (cmd.step) begin
      idx_r <= idx_r + IW'(1);
    end
    if (cmd.clr_result) begin
      status_r <= bshl_pkg::ST_NOT_FOUND;
      flags_r  <= '0;
      id_r     <= '0;
    end
    if (cmd.set_wrong) begin
      status_r <= bshl_pkg::ST_WRONG;
    end
    if (cmd.step && first_eq && q_eq) begin
      flags_r  <= bshl_pkg::decode_flags(fi_q_r[15:0]);
      id_r     <= fi_q_r[31:16];
      status_r <= (is_plain || m_eq) ? bshl_pkg::ST_FOUND : bshl_pkg::ST_MISMATCH;
    end
  end

  logic [1:0] want;
  assign want = is_plain ? bshl_pkg::KIND_PLAIN : bshl_pkg::KIND_MATCH;

  assign sts.is_write     = (cmd_r == bshl_pkg::CMD_WR_BUCKET) ||
                            (cmd_r == bshl_pkg::CMD_WR_RECORD);
  assign sts.kind_none    = (table_kind == bshl_pkg::KIND_NONE);
  assign sts.kind_ok      = (table_kind == want);
  assign sts.bucket_empty = (bucket_eff == 16'd0);
  assign sts.idx_oob      = ({{(32-IW){1'b0}}, idx_r} >= 32'(RECORD_DEPTH));
  assign sts.walk_done    = !first_eq || q_lt || (q_eq && (is_plain || m_eq));

  assign out_status   = status_r;
  assign out_flags    = flags_r;
  assign out_entry_id = id_r;

endmodule

/* hdl/bucketed_sorted_hash_lookup.sv */
// ----------------------------------------------------------------------------
// bucketed_sorted_hash_lookup
// Steps: write is captured in S_IDLE, done in S_DECODE; lookup with no table or wrong
// kind goes to S_OUT, else S_BUCKET, then S_INDEX, S_READ, S_EVAL per record, S_OUT.
// Throughput: one transaction at a time; next input taken the cycle after the result is accepted.
// Reset: synchronous active-low rst_n clears FSM, table_kind and bucket valid
// bits; record memories are undefined until written, no clearing pass.
// ----------------------------------------------------------------------------
module bucketed_sorted_hash_lookup #(
  parameter int unsigned RECORD_DEPTH = bshl_pkg::RECORD_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  bshl_in_if.sink    in_ch,
  bshl_out_if.source out_ch,
  bshl_cfg_if.sink   cfg_ch
);

  bshl_pkg::dp_cmd_t    cmd;
  bshl_pkg::dp_status_t sts;
  logic [1:0] table_kind_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_kind_r <= bshl_pkg::KIND_NONE;
    end else if (cfg_ch.valid) begin
      table_kind_r <= cfg_ch.data;
    end
  end

  bshl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  bshl_dp #(.RECORD_DEPTH(RECORD_DEPTH)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .table_kind   (table_kind_r),
    .in_cmd       (in_ch.cmd),
    .in_slot      (in_ch.slot),
    .in_part      (in_ch.part),
    .in_load_word (in_ch.load_word),
    .in_hash_hi   (in_ch.hash_hi),
    .in_hash_lo   (in_ch.hash_lo),
    .in_match_hi  (in_ch.match_hi),
    .in_match_lo  (in_ch.match_lo),
    .cmd          (cmd),
    .sts          (sts),
    .out_status   (out_ch.status),
    .out_flags    (out_ch.flags),
    .out_entry_id (out_ch.entry_id)
  );

endmodule

/* hdl/bshl_checker.sv */
// ----------------------------------------------------------------------------
// bshl_checker
// Port-level checks of the lookup block, bound to the top level.
// ----------------------------------------------------------------------------
module bshl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [31:0] out_flags,
  input logic [15:0] out_entry_id
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result dropped while stalled");

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while result pending");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == 2'd0 || out_status == 2'd3) |->
    out_flags == 32'd0 && out_entry_id == 16'd0)
    else $error("nonzero payload without a hit");

  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid)
    else $error("result too early");

endmodule

bind bucketed_sorted_hash_lookup bshl_checker u_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_status   (out_ch.status),
  .out_flags    (out_ch.flags),
  .out_entry_id (out_ch.entry_id)
);

/* dv/lookup_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lookup_checker
// Watches the input, result and configuration channels of the lookup block.
// Keeps its own copy of the bucket index and record store, predicts the
// answer of every accepted lookup and compares it with the returned result.
// ----------------------------------------------------------------------------
module lookup_checker
  import bshl_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  bshl_in_if   in_mon,
  bshl_out_if  out_mon,
  bshl_cfg_if  cfg_mon,
  output int   fail_count,
  output int   pending
);

  localparam int unsigned DEPTH = RECORD_DEPTH_DEF;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] flags;
    logic [15:0] entry_id;
  } answer_t;

  logic [15:0] bucket_start [BUCKETS];
  logic [63:0] rec_hash_hi  [DEPTH];
  logic [63:0] rec_hash_lo  [DEPTH];
  logic [63:0] rec_match_hi [DEPTH];
  logic [63:0] rec_match_lo [DEPTH];
  logic [31:0] rec_flag_id  [DEPTH];
  logic [1:0]  table_kind;
  answer_t     expected_answers [$];

  function automatic logic [31:0] expand_flags(input logic [15:0] raw);
    if (raw[15]) begin
      return 32'd1 << raw[4:0];
    end
    return {16'd0, raw};
  endfunction

  function automatic answer_t predict_answer(input logic [1:0] cmd,
                                             input logic [63:0] qh,
                                             input logic [63:0] ql,
                                             input logic [63:0] mh,
                                             input logic [63:0] ml);
    answer_t    ans;
    logic [1:0] want;
    logic [7:0] first;
    int         idx;
    ans  = '0;
    want = (cmd == CMD_LOOKUP) ? KIND_PLAIN : KIND_MATCH;
    if (table_kind == KIND_NONE) begin
      ans.status = ST_NOT_FOUND;
    end else if (table_kind != want) begin
      ans.status = ST_WRONG;
    end else begin
      first = qh[63:56];
      idx   = bucket_start[first];
      if (idx != 0) begin
        idx--;
        while (idx < DEPTH && rec_hash_hi[idx][63:56] == first) begin
          if (qh == rec_hash_hi[idx] && ql == rec_hash_lo[idx]) begin
            ans.flags    = expand_flags(rec_flag_id[idx][15:0]);
            ans.entry_id = rec_flag_id[idx][31:16];
            if (want == KIND_PLAIN ||
                (rec_match_hi[idx] == mh && rec_match_lo[idx] == ml)) begin
              ans.status = ST_FOUND;
              break;
            end
            ans.status = ST_MISMATCH;
          end else if ({qh, ql} < {rec_hash_hi[idx], rec_hash_lo[idx]}) begin
            break;
          end
          idx++;
        end
      end
    end
    return ans;
  endfunction

  always @(posedge clk) begin
    answer_t got;
    answer_t want_ans;
    if (!rst_n) begin
      table_kind = KIND_NONE;
      for (int i = 0; i < BUCKETS; i++) bucket_start[i] = '0;
      expected_answers.delete();
      fail_count = 0;
      pending    = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        table_kind = cfg_mon.data;
      end
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.status, out_mon.flags, out_mon.entry_id};
        if (expected_answers.size() == 0) begin
          $error("unexpected result transaction status=%0d flags=%h id=%h",
                 got.status, got.flags, got.entry_id);
          fail_count++;
        end else begin
          want_ans = expected_answers.pop_front();
          if (got.status !== want_ans.status) begin
            $error("status: expected %0d, actual %0d", want_ans.status, got.status);
            fail_count++;
          end
          if (got.flags !== want_ans.flags) begin
            $error("flags: expected %h, actual %h", want_ans.flags, got.flags);
            fail_count++;
          end
          if (got.entry_id !== want_ans.entry_id) begin
            $error("entry_id: expected %h, actual %h", want_ans.entry_id, got.entry_id);
            fail_count++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        case (cmd_t'(in_mon.cmd))
          CMD_WR_BUCKET: begin
            if (in_mon.slot < BUCKETS) bucket_start[in_mon.slot[7:0]] = in_mon.load_word[15:0];
          end
          CMD_WR_RECORD: begin
            if (in_mon.slot < DEPTH) begin
              case (in_mon.part)
                PART_HASH_HI:  rec_hash_hi[in_mon.slot]  = in_mon.load_word;
                PART_HASH_LO:  rec_hash_lo[in_mon.slot]  = in_mon.load_word;
                PART_MATCH_HI: rec_match_hi[in_mon.slot] = in_mon.load_word;
                PART_MATCH_LO: rec_match_lo[in_mon.slot] = in_mon.load_word;
                PART_FLAG_ID:  rec_flag_id[in_mon.slot]  = in_mon.load_word[31:0];
                default: ;
              endcase
            end
          end
          default: begin
            expected_answers.push_back(predict_answer(in_mon.cmd, in_mon.hash_hi,
                in_mon.hash_lo, in_mon.match_hi, in_mon.match_lo));
          end
        endcase
      end
      pending = expected_answers.size();
    end
  end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Loads sorted, bucketed record tables into the lookup block and fires plain
// and match lookups at them under every table kind, with bursty input and a
// stalling result sink. The checker predicts and compares every answer.
// ----------------------------------------------------------------------------
module tb_top;
  import bshl_pkg::*;

  localparam int unsigned DEPTH = RECORD_DEPTH_DEF;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   lookups_sent;
  int   answers_seen;
  int   burst_left;
  int   stall_cnt;
  int   stall_mode;

  logic [63:0] tbl_hi [64];
  logic [63:0] tbl_lo [64];
  logic [63:0] tbl_mh [64];
  logic [63:0] tbl_ml [64];
  int          tbl_n;
  logic [7:0]  used_buckets [$];

  bshl_in_if  in_ch ();
  bshl_out_if out_ch ();
  bshl_cfg_if cfg_ch ();

  bucketed_sorted_hash_lookup u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  lookup_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_mon    (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  always @(posedge clk) begin
    stall_cnt++;
    if (stall_cnt % 97 == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0:       out_ch.ready <= 1'b1;
      1:       out_ch.ready <= ($urandom_range(0, 1) == 1);
      default: out_ch.ready <= ($urandom_range(0, 3) == 0);
    endcase
    if (out_ch.valid && out_ch.ready) answers_seen++;
  end

  task automatic send_item(input logic [1:0] cmd, input logic [11:0] slot,
                           input logic [2:0] part, input logic [63:0] word,
                           input logic [63:0] qh, input logic [63:0] ql,
                           input logic [63:0] mh, input logic [63:0] ml);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_ch.valid     <= 1'b1;
    in_ch.cmd       <= cmd;
    in_ch.slot      <= slot;
    in_ch.part      <= part;
    in_ch.load_word <= word;
    in_ch.hash_hi   <= qh;
    in_ch.hash_lo   <= ql;
    in_ch.match_hi  <= mh;
    in_ch.match_lo  <= ml;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (cmd == CMD_LOOKUP || cmd == CMD_MATCH) lookups_sent++;
  endtask

  task automatic write_bucket(input int b, input logic [15:0] start);
    send_item(CMD_WR_BUCKET, 12'(b), 3'($urandom), {rand64() & ~64'hFFFF} | {48'd0, start},
              rand64(), rand64(), rand64(), rand64());
  endtask

  task automatic write_record(input int idx, input logic [63:0] hh, input logic [63:0] hl,
                              input logic [63:0] mh, input logic [63:0] ml,
                              input logic [63:0] fid);
    send_item(CMD_WR_RECORD, 12'(idx), PART_HASH_HI, hh, rand64(), rand64(), rand64(),
              rand64());
    send_item(CMD_WR_RECORD, 12'(idx), PART_HASH_LO, hl, rand64(), rand64(), rand64(),
              rand64());
    send_item(CMD_WR_RECORD, 12'(idx), PART_MATCH_HI, mh, rand64(), rand64(), rand64(),
              rand64());
    send_item(CMD_WR_RECORD, 12'(idx), PART_MATCH_LO, ml, rand64(), rand64(), rand64(),
              rand64());
    send_item(CMD_WR_RECORD, 12'(idx), PART_FLAG_ID, fid, rand64(), rand64(), rand64(),
              rand64());
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (answers_seen != lookups_sent) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_kind(input logic [1:0] k);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= k;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    repeat (2) @(posedge clk);
  endtask

  task automatic load_table(input bit at_end);
    int          base;
    int          groups;
    int          grp;
    int          prev_grp;
    logic [7:0]  gbyte [6];
    logic [63:0] hh;
    logic [63:0] hl;
    logic [63:0] pool_hi [2];
    logic [63:0] pool_lo [2];
    int          pick;
    // clear every bucket a previous table touched
    while (used_buckets.size() != 0) write_bucket(used_buckets.pop_front(), 16'd0);
    tbl_n  = $urandom_range(4, 40);
    base   = at_end ? DEPTH - tbl_n : $urandom_range(0, DEPTH - tbl_n - 1);
    groups = $urandom_range(1, 5);
    gbyte[0] = 8'($urandom_range(0, 40));
    for (int g = 1; g < groups; g++) begin
      if (gbyte[g-1] > 200) groups = g;
      else gbyte[g] = gbyte[g-1] + 8'($urandom_range(1, 50));
    end
    for (int p = 0; p < 2; p++) begin
      pool_hi[p] = rand64();
      pool_lo[p] = rand64();
    end
    prev_grp = -1;
    hh = '0;
    hl = '0;
    for (int i = 0; i < tbl_n; i++) begin
      grp = i * groups / tbl_n;
      if (grp != prev_grp) begin
        hh = {gbyte[grp], 8'h00, 48'(rand64())};
        hl = rand64() & 64'h7FFF_FFFF_FFFF_FFFF;
        if (gbyte[grp] == 8'h00 && $urandom_range(0, 1) == 1) hh[55:0] = '0;
      end else if ($urandom_range(0, 3) != 0) begin
        if ($urandom_range(0, 7) == 0) hh = hh + 64'd1;
        else hl = hl + 64'($urandom_range(1, 3));
      end
      prev_grp = grp;
      pick = $urandom_range(0, 2);
      tbl_hi[i] = hh;
      tbl_lo[i] = hl;
      tbl_mh[i] = (pick == 2) ? rand64() : pool_hi[pick];
      tbl_ml[i] = (pick == 2) ? rand64() : pool_lo[pick];
      write_record(base + i, tbl_hi[i], tbl_lo[i], tbl_mh[i], tbl_ml[i], rand64());
      if ($urandom_range(0, 9) == 0) begin
        send_item(CMD_WR_RECORD, 12'($urandom), 3'($urandom_range(5, 7)), rand64(),
                  rand64(), rand64(), rand64(), rand64());
      end
    end
    if (!at_end) begin
      write_record(base + tbl_n, {hh[63:56] ^ 8'h01, 56'(rand64())},
                   rand64(), rand64(), rand64(), rand64());
    end
    prev_grp = -1;
    for (int i = 0; i < tbl_n; i++) begin
      grp = i * groups / tbl_n;
      if (grp != prev_grp) begin
        write_bucket(gbyte[grp], 16'(base + i + 1));
        used_buckets.push_back(gbyte[grp]);
      end
      prev_grp = grp;
    end
    repeat ($urandom_range(1, 4)) begin
      pick = $urandom_range(0, 255);
      used_buckets.push_back(8'(pick));
      if ($urandom_range(0, 1) == 1) write_bucket(pick, 16'($urandom_range(DEPTH + 1, 65535)));
      else write_bucket(pick, 16'(base + 1 + $urandom_range(0, tbl_n - 1)));
    end
    send_item(CMD_WR_BUCKET, 12'($urandom_range(256, 4095)), 3'($urandom), rand64(),
              rand64(), rand64(), rand64(), rand64());
  endtask

  task automatic random_lookups(input int count, input logic [1:0] kind);
    int          mode;
    int          i;
    logic [1:0]  cmd;
    logic [63:0] qh;
    logic [63:0] ql;
    logic [63:0] mh;
    logic [63:0] ml;
    repeat (count) begin
      if ($urandom_range(0, 7) == 0) cmd = ($urandom_range(0, 1) == 1) ? CMD_MATCH : CMD_LOOKUP;
      else cmd = (kind == KIND_MATCH) ? CMD_MATCH : CMD_LOOKUP;
      i    = $urandom_range(0, tbl_n - 1);
      mode = $urandom_range(0, 9);
      qh   = tbl_hi[i];
      ql   = tbl_lo[i];
      if (mode == 6) ql = ql + 64'd1;
      else if (mode == 7) ql = ql - 64'd1;
      else if (mode == 8) qh[7:0] = qh[7:0] ^ 8'h01;
      else if (mode == 9) begin
        qh = rand64();
        ql = rand64();
      end
      mh = tbl_mh[i];
      ml = tbl_ml[i];
      if ($urandom_range(0, 2) == 0) begin
        if ($urandom_range(0, 1) == 1) mh = rand64();
        else ml = rand64();
      end
      send_item(cmd, 12'($urandom), 3'($urandom), rand64(), qh, ql, mh, ml);
    end
  endtask

  initial begin
    logic [1:0] kinds [8];
    kinds = '{KIND_PLAIN, KIND_MATCH, KIND_PLAIN, KIND_MATCH,
              2'd3, KIND_NONE, KIND_MATCH, KIND_PLAIN};
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.cmd      = '0;
    in_ch.slot     = '0;
    in_ch.part     = '0;
    in_ch.load_word = '0;
    in_ch.hash_hi  = '0;
    in_ch.hash_lo  = '0;
    in_ch.match_hi = '0;
    in_ch.match_lo = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.data    = '0;
    lookups_sent   = 0;
    burst_left     = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed: empty table, wrong kinds, ignored writes, start beyond store
    write_kind(KIND_NONE);
    send_item(CMD_LOOKUP, '1, '1, '1, '1, '1, '1, '1);
    send_item(CMD_MATCH, '0, '0, '0, '0, '0, '0, '0);
    send_item(CMD_WR_BUCKET, 12'd4095, '0, '1, '0, '0, '0, '0);
    send_item(CMD_WR_RECORD, 12'd7, 3'd7, '1, '0, '0, '0, '0);
    send_item(CMD_WR_BUCKET, 12'h05A, '0, 64'hFFFF, '0, '0, '0, '0);
    used_buckets.push_back(8'h5A);
    wait_idle();
    write_kind(2'd3);
    send_item(CMD_LOOKUP, '0, '0, '0, {8'h5A, 56'd0}, '0, '0, '0);
    send_item(CMD_MATCH, '0, '0, '0, '1, '1, '1, '1);
    wait_idle();
    write_kind(KIND_PLAIN);
    send_item(CMD_LOOKUP, '0, '0, '0, {8'h5A, 56'd1}, '0, '0, '0);
    send_item(CMD_MATCH, '0, '0, '0, {8'h5A, 56'd1}, '0, '0, '0);
    send_item(CMD_LOOKUP, '0, '0, '0, '1, '1, '0, '0);
    wait_idle();
    write_kind(KIND_MATCH);
    send_item(CMD_LOOKUP, '0, '0, '0, '0, '0, '0, '0);
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      load_table(ph == 2 || ph == 6);
      wait_idle();
      write_kind(kinds[ph]);
      random_lookups(40, kinds[ph]);
      wait_idle();
    end

    while (pending != 0 || answers_seen != lookups_sent) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* bucketed_sorted_hash_lookup.f */
hdl/bshl_pkg.sv
hdl/bshl_if.sv
hdl/bshl_ctrl.sv
hdl/bshl_dp.sv
hdl/bucketed_sorted_hash_lookup.sv
hdl/bshl_checker.sv
dv/lookup_checker.sv
dv/tb_top.sv
